// ----- rtl/core/ptc_pkg.sv -----
// Shared types, register indexes, reset values and the gain multiply
// for the heading PID turn controller. No dependencies.
`default_nettype none
package ptc_pkg;

  localparam int POWER_MAX = 25600;

  // configuration register indexes
  localparam logic [2:0] REG_GAIN_P       = 3'd0;
  localparam logic [2:0] REG_GAIN_D       = 3'd1;
  localparam logic [2:0] REG_GAIN_I       = 3'd2;
  localparam logic [2:0] REG_INTEG_CAP    = 3'd3;
  localparam logic [2:0] REG_SETTLE_BAND  = 3'd4;
  localparam logic [2:0] REG_SETTLE_COUNT = 3'd5;
  localparam logic [2:0] REG_CCW          = 3'd6;

  localparam logic [19:0] RST_GAIN_P       = 20'd36045;
  localparam logic [19:0] RST_GAIN_D       = 20'd15073;
  localparam logic [19:0] RST_GAIN_I       = 20'd131;
  localparam logic [14:0] RST_INTEG_CAP    = 15'd7680;
  localparam logic [15:0] RST_SETTLE_BAND  = 16'd128;
  localparam logic [7:0]  RST_SETTLE_COUNT = 8'd4;

  typedef struct packed {
    logic [19:0] gain_p;
    logic [19:0] gain_d;
    logic [19:0] gain_i;
    logic [14:0] integral_cap;
    logic [15:0] settle_band;
    logic [7:0]  settle_samples;
    logic        counter_clockwise;
  } cfg_t;

  typedef struct packed {
    logic               action;
    logic signed [17:0] goal_angle;
    logic signed [16:0] yaw_angle;
  } in_item_t;

  // error stage to drive stage
  typedef struct packed {
    logic               done;
    logic               start;
    logic               in_zone;
    logic signed [25:0] p_term;
    logic signed [25:0] d_term;
    logic signed [25:0] i_step;
  } mid_item_t;

  // gain * v / 65536, rounded to nearest, ties away from zero
  function automatic logic signed [25:0] mul_gain(input logic [19:0] gain,
                                                  input logic signed [19:0] v);
    logic [19:0] mag;
    logic [40:0] prod;
    logic [24:0] r;
    mag  = v[19] ? 20'(-v) : 20'(v);
    prod = 41'(gain) * 41'(mag) + 41'd32768;
    r    = prod[40:16];
    mul_gain = v[19] ? -$signed({1'b0, r}) : $signed({1'b0, r});
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/ptc_cfg_regs.sv -----
// Configuration register file of the turn controller.
// Depends on ptc_pkg.
`default_nettype none
module ptc_cfg_regs (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cfg_we,
  input  wire logic [2:0]    cfg_index,
  input  wire logic [19:0]   cfg_data,
  output ptc_pkg::cfg_t      cfg
);

  ptc_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain_p            <= ptc_pkg::RST_GAIN_P;
      cfg_r.gain_d            <= ptc_pkg::RST_GAIN_D;
      cfg_r.gain_i            <= ptc_pkg::RST_GAIN_I;
      cfg_r.integral_cap      <= ptc_pkg::RST_INTEG_CAP;
      cfg_r.settle_band       <= ptc_pkg::RST_SETTLE_BAND;
      cfg_r.settle_samples    <= ptc_pkg::RST_SETTLE_COUNT;
      cfg_r.counter_clockwise <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        ptc_pkg::REG_GAIN_P:       cfg_r.gain_p            <= cfg_data;
        ptc_pkg::REG_GAIN_D:       cfg_r.gain_d            <= cfg_data;
        ptc_pkg::REG_GAIN_I:       cfg_r.gain_i            <= cfg_data;
        ptc_pkg::REG_INTEG_CAP:    cfg_r.integral_cap      <= cfg_data[14:0];
        ptc_pkg::REG_SETTLE_BAND:  cfg_r.settle_band       <= cfg_data[15:0];
        ptc_pkg::REG_SETTLE_COUNT: cfg_r.settle_samples    <= cfg_data[7:0];
        ptc_pkg::REG_CCW:          cfg_r.counter_clockwise <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

// ----- rtl/core/ptc_error_stage.sv -----
// Error stage: heading error, settle rule, turn state, and the P, D and
// integral-step products. Depends on ptc_pkg.
`default_nettype none
module ptc_error_stage (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire ptc_pkg::cfg_t cfg,
  input  wire ptc_pkg::in_item_t item,
  input  wire logic          fire,
  output ptc_pkg::mid_item_t mid
);

  logic signed [17:0] target_r, target_nxt;
  logic signed [18:0] prev_r, prev_nxt;
  logic [16:0]        zone_r, zone_nxt;
  logic [7:0]         cnt_r, cnt_nxt;
  logic               finished_r, finished_nxt;

  logic               start;
  logic signed [17:0] tgt;
  logic signed [18:0] goal19;
  logic [18:0]        goal_abs;
  logic [16:0]        zone_cur;
  logic signed [18:0] err;
  logic [18:0]        err_abs;
  logic signed [18:0] prev_cur;
  logic signed [19:0] diff;
  logic               in_band;
  logic               done;

  always_comb begin
    start    = ~item.action;
    tgt      = start ? item.goal_angle : target_r;
    goal19   = 19'(item.goal_angle);
    goal_abs = goal19[18] ? 19'(-goal19) : 19'(goal19);
    zone_cur = start ? goal_abs[18:2] : zone_r;
    err      = 19'(tgt) - 19'(item.yaw_angle);
    err_abs  = err[18] ? 19'(-err) : 19'(err);
    prev_cur = start ? err : prev_r;
    diff     = 20'(err) - 20'(prev_cur);
    in_band  = err_abs < 19'(cfg.settle_band);

    target_nxt   = target_r;
    prev_nxt     = prev_r;
    zone_nxt     = zone_r;
    cnt_nxt      = cnt_r;
    finished_nxt = finished_r;
    done         = 1'b0;

    if (start) begin
      target_nxt   = item.goal_angle;
      prev_nxt     = err;
      zone_nxt     = zone_cur;
      cnt_nxt      = 8'd0;
      finished_nxt = 1'b0;
    end else if (finished_r) begin
      done = 1'b1;
    end else begin
      if (in_band) begin
        if (cnt_r >= cfg.settle_samples) begin
          finished_nxt = 1'b1;
          done         = 1'b1;
        end else begin
          cnt_nxt = cnt_r + 8'd1;
        end
      end else begin
        cnt_nxt = 8'd0;
      end
      if (!done) prev_nxt = err;
    end

    mid.done    = done;
    mid.start   = start;
    mid.in_zone = (err != 19'sd0) && (err_abs < 19'(zone_cur));
    mid.p_term  = ptc_pkg::mul_gain(cfg.gain_p, 20'(err));
    mid.d_term  = (err == 19'sd0) ? 26'sd0 : ptc_pkg::mul_gain(cfg.gain_d, diff);
    mid.i_step  = ptc_pkg::mul_gain(cfg.gain_i, 20'(err));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r   <= '0;
      prev_r     <= '0;
      zone_r     <= '0;
      cnt_r      <= '0;
      finished_r <= 1'b1;
    end else if (fire) begin
      target_r   <= target_nxt;
      prev_r     <= prev_nxt;
      zone_r     <= zone_nxt;
      cnt_r      <= cnt_nxt;
      finished_r <= finished_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/ptc_drive_stage.sv -----
// Drive stage: integral accumulate and clamp, P+I+D sum, saturation and
// side signs. Depends on ptc_pkg.
`default_nettype none
module ptc_drive_stage (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire ptc_pkg::cfg_t cfg,
  input  wire ptc_pkg::mid_item_t mid,
  input  wire logic          fire,
  output logic signed [15:0] left_power,
  output logic signed [15:0] right_power,
  output logic               settled
);

  logic signed [15:0] integ_r, integ_nxt;
  logic signed [15:0] base;
  logic signed [26:0] acc;
  logic signed [26:0] cap_s;
  logic signed [27:0] total;
  logic signed [15:0] power;

  always_comb begin
    base  = mid.start ? 16'sd0 : integ_r;
    acc   = 27'(base) + 27'(mid.i_step);
    cap_s = $signed({12'd0, cfg.integral_cap});
    if (!mid.in_zone) acc = 27'sd0;
    if (acc > cap_s)       integ_nxt = 16'(cap_s);
    else if (acc < -cap_s) integ_nxt = 16'(-cap_s);
    else                   integ_nxt = 16'(acc);

    total = 28'(mid.p_term) + 28'(integ_nxt) + 28'(mid.d_term);
    if (total > 28'(ptc_pkg::POWER_MAX))       power = 16'(ptc_pkg::POWER_MAX);
    else if (total < -28'(ptc_pkg::POWER_MAX)) power = -16'(ptc_pkg::POWER_MAX);
    else                                       power = 16'(total);
    if (mid.done) power = 16'sd0;
    if (cfg.counter_clockwise) power = -power;

    left_power  = power;
    right_power = -power;
    settled     = mid.done;
  end

  // a finishing or idle sample leaves the integral alone
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_r <= '0;
    end else if (fire && !mid.done) begin
      integ_r <= integ_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/pid_turn_controller_top.sv -----
// Heading PID turn controller, top level: input register, error stage,
// drive stage and result register. Depends on ptc_pkg, ptc_cfg_regs,
// ptc_error_stage and ptc_drive_stage.
// Items pass the input, stage and result registers in turn. Throughput:
// one item per cycle, three-register pipeline, unless out_ready stalls.
// Reset (rst_n low, synchronous): pipeline empty, registers at defaults,
// turn idle (samples answer settled until a start item).
`default_nettype none
module pid_turn_controller_top (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               in_action,
  input  wire logic signed [17:0] in_goal_angle,
  input  wire logic signed [16:0] in_yaw_angle,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [15:0]      out_left_power,
  output logic signed [15:0]      out_right_power,
  output logic                    out_settled,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [19:0]        cfg_data
);

  ptc_pkg::cfg_t      cfg;
  ptc_pkg::in_item_t  s1_r;
  ptc_pkg::mid_item_t mid_nxt, mid_r;
  logic               s1_v_r, s2_v_r, out_v_r;
  logic               out_take, s2_take, fire1, fire2;
  logic signed [15:0] left_nxt, right_nxt;
  logic               settled_nxt;
  logic signed [15:0] left_r, right_r;
  logic               settled_r;

  assign out_take = ~out_v_r | out_ready;
  assign fire2    = s2_v_r & out_take;
  assign s2_take  = ~s2_v_r | out_take;
  assign fire1    = s1_v_r & s2_take;
  // no item is taken while reset is held
  assign in_ready = rst_n & (~s1_v_r | s2_take);

  ptc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ptc_error_stage u_err (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg),
    .item  (s1_r),
    .fire  (fire1),
    .mid   (mid_nxt)
  );

  ptc_drive_stage u_drv (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .mid         (mid_r),
    .fire        (fire2),
    .left_power  (left_nxt),
    .right_power (right_nxt),
    .settled     (settled_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_ready) s1_v_r <= in_valid;
      if (s2_take)  s2_v_r <= s1_v_r;
      if (out_take) out_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_r.action     <= in_action;
      s1_r.goal_angle <= in_goal_angle;
      s1_r.yaw_angle  <= in_yaw_angle;
    end
    if (fire1) mid_r <= mid_nxt;
    if (fire2) begin
      left_r    <= left_nxt;
      right_r   <= right_nxt;
      settled_r <= settled_nxt;
    end
  end

  assign out_valid       = out_v_r;
  assign out_left_power  = left_r;
  assign out_right_power = right_r;
  assign out_settled     = settled_r;

endmodule
`default_nettype wire
